[hw/rtl/inclusion_maximal_mask_filter_core_assert.svh]
// Assertion macros used by the filter core RTL.
`ifndef INCLUSION_MAXIMAL_MASK_FILTER_CORE_ASSERT_SVH
`define INCLUSION_MAXIMAL_MASK_FILTER_CORE_ASSERT_SVH

// Implication that must hold at every clock edge outside reset.
`define IMF_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication outside reset.
`define IMF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

[hw/rtl/imf_pkg.sv]
package imf_pkg;

    localparam int unsigned IDX_W = 6;
    localparam int unsigned PLY_W = 7;

    // Phase codes of the sequencer.
    localparam logic [2:0] PH_LOAD  = 3'd0;
    localparam logic [2:0] PH_PCNT  = 3'd1;
    localparam logic [2:0] PH_SCAN  = 3'd2;
    localparam logic [2:0] PH_CHECK = 3'd3;
    localparam logic [2:0] PH_EMIT  = 3'd4;

    function automatic logic [PLY_W-1:0] popcount64(input logic [63:0] v);
        logic [PLY_W-1:0] n;
        n = '0;
        for (int k = 0; k < 64; k++) begin
            n = n + {{(PLY_W-1){1'b0}}, v[k]};
        end
        return n;
    endfunction

endpackage

[hw/rtl/inclusion_maximal_mask_filter_core.sv]
// Channel | Direction | Handshake          | Fields
// in      | input     | i_valid / o_ready  | i_mask_inclusive, i_mask_conservative, i_set_end
// out     | output    | o_valid / i_ready  | o_cand_index, o_ply, o_is_maximal, o_run_last
//
// Load: one candidate per cycle into the mask memories, while in the load phase.
// After the close: a popcount pass, then for each popcount level from
// MASK_BITS down to zero, a scan of all N candidates; each candidate at the
// level is checked against the survivors so far until one covers it.
// Emit: one result at a time, in arrival order; stalls hold the output.
// Reset (synchronous, active low) clears counters; memories are not cleared, and the
// keep flag of every candidate is written during the filter pass before it is emitted.
`include "inclusion_maximal_mask_filter_core_assert.svh"

module inclusion_maximal_mask_filter_core #(
    parameter int MAX_CANDIDATES = 64,
    parameter int MASK_BITS      = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [63:0]               i_mask_inclusive,
    input  logic [63:0]               i_mask_conservative,
    input  logic                      i_set_end,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [imf_pkg::IDX_W-1:0] o_cand_index,
    output logic [imf_pkg::PLY_W-1:0] o_ply,
    output logic                      o_is_maximal,
    output logic                      o_run_last
);
    localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_CANDIDATES - 1);
    localparam logic [imf_pkg::PLY_W-1:0] TOP_PLY = imf_pkg::PLY_W'(MASK_BITS);

    // Mask memories: one read port each, registered read.
    logic [MASK_BITS-1:0] r_inc_mem [MAX_CANDIDATES];
    logic [MASK_BITS-1:0] r_con_mem [MAX_CANDIDATES];
    logic [imf_pkg::PLY_W-1:0] r_pc_mem [MAX_CANDIDATES];
    logic [AW-1:0] r_surv_mem [MAX_CANDIDATES];
    logic r_keep_mem [MAX_CANDIDATES];
    logic [MASK_BITS-1:0] r_inc_q, r_con_q;
    logic [imf_pkg::PLY_W-1:0] r_pc_q;
    logic [AW-1:0] r_surv_q;
    logic r_keep_q;

    logic [2:0]  r_phase;
    logic [CW-1:0] r_count, r_surv_cnt;
    logic [CW-1:0] r_i, r_s;       // candidate and survivor cursors
    logic [1:0]  r_sub;            // sub-step inside a scan, check or emit / pipeline fill
    logic [imf_pkg::PLY_W-1:0] r_level;
    logic [MASK_BITS-1:0] r_cand;  // inclusive mask of candidate under test
    logic [CW-1:0] r_pc_wr;        // popcount write pointer (lags by latency)

    logic [AW-1:0] w_inc_addr, w_surv_addr, w_pc_addr;
    logic [imf_pkg::PLY_W-1:0] w_pc;
    logic w_in_acc, w_out_acc, w_close;

    imf_popcount #(.MASK_BITS(MASK_BITS)) u_pc (
        .i_clk  (i_clk),
        .i_value(r_inc_q),
        .o_count(w_pc)
    );

    assign o_ready   = (r_phase == imf_pkg::PH_LOAD);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign w_close   = i_set_end || (r_count == LAST_SLOT);

    // Address selection for the shared read ports.
    always_comb begin
        w_inc_addr  = r_i[AW-1:0];
        w_pc_addr   = r_i[AW-1:0];
        w_surv_addr = r_s[AW-1:0];
        if (r_phase == imf_pkg::PH_CHECK) begin
            w_inc_addr = r_surv_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_inc_mem[r_count[AW-1:0]] <= i_mask_inclusive[MASK_BITS-1:0];
            r_con_mem[r_count[AW-1:0]] <= i_mask_conservative[MASK_BITS-1:0];
        end
        r_inc_q  <= r_inc_mem[w_inc_addr];
        r_con_q  <= r_con_mem[w_inc_addr];
        r_pc_q   <= r_pc_mem[w_pc_addr];
        r_surv_q <= r_surv_mem[w_surv_addr];
        r_keep_q <= r_keep_mem[w_pc_addr];
        if (r_phase == imf_pkg::PH_PCNT && r_sub == 2'd2) begin
            r_pc_mem[r_pc_wr[AW-1:0]] <= w_pc;
        end
        if (r_phase == imf_pkg::PH_CHECK && r_sub == 2'd1 && r_s == r_surv_cnt) begin
            r_surv_mem[r_surv_cnt[AW-1:0]] <= r_i[AW-1:0];
            r_keep_mem[r_i[AW-1:0]]        <= 1'b1;
        end
        if (r_phase == imf_pkg::PH_CHECK && r_sub == 2'd2 && (r_cand & ~r_con_q) == '0) begin
            r_keep_mem[r_i[AW-1:0]] <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= imf_pkg::PH_LOAD;
            r_count    <= '0;
            r_surv_cnt <= '0;
            r_i        <= '0;
            r_s        <= '0;
            r_sub      <= '0;
            r_level    <= '0;
            r_pc_wr    <= '0;
            o_valid    <= 1'b0;
        end else begin
            case (r_phase)
                imf_pkg::PH_LOAD: begin
                    if (w_in_acc) begin
                        r_count <= r_count + 1'b1;
                        if (w_close) begin
                            r_phase    <= imf_pkg::PH_PCNT;
                            r_i        <= '0;
                            r_sub      <= '0;
                            r_pc_wr    <= '0;
                            r_surv_cnt <= '0;
                        end
                    end
                end
                imf_pkg::PH_PCNT: begin
                    // Read address r_i leads the popcount write by the read and popcount registers.
                    if (r_i < r_count) r_i <= r_i + 1'b1;
                    if (r_sub != 2'd2) begin
                        r_sub <= r_sub + 1'b1;
                    end else begin
                        r_pc_wr <= r_pc_wr + 1'b1;
                        if (r_pc_wr + 1'b1 == r_count) begin
                            r_phase <= imf_pkg::PH_SCAN;
                            r_level <= TOP_PLY;
                            r_i     <= '0;
                            r_sub   <= '0;
                        end
                    end
                end
                imf_pkg::PH_SCAN: begin
                    // sub 0 issues read of r_i, sub 1 tests popcount.
                    if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else if (r_pc_q == r_level) begin
                        r_cand  <= r_inc_q;
                        r_s     <= '0;
                        r_sub   <= 2'd0;
                        r_phase <= imf_pkg::PH_CHECK;
                    end else begin
                        r_sub <= 2'd0;
                        if (r_i + 1'b1 == r_count) begin
                            r_i <= '0;
                            if (r_level == '0) begin
                                r_phase <= imf_pkg::PH_EMIT;
                                r_sub   <= '0;
                            end else begin
                                r_level <= r_level - 1'b1;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                imf_pkg::PH_CHECK: begin
                    // sub 0: survivor index read; sub 1: issue its masks; sub 2: compare.
                    if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else if (r_sub == 2'd1) begin
                        if (r_s == r_surv_cnt) begin
                            r_surv_cnt <= r_surv_cnt + 1'b1;
                            r_sub <= 2'd3;
                        end else begin
                            r_sub <= 2'd2;
                        end
                    end else if (r_sub == 2'd2) begin
                        if ((r_cand & ~r_con_q) == '0) begin
                            r_sub <= 2'd3;
                        end else begin
                            r_s   <= r_s + 1'b1;
                            r_sub <= 2'd0;
                        end
                    end else begin
                        // Advance to the next candidate of the scan.
                        r_sub   <= 2'd0;
                        r_phase <= imf_pkg::PH_SCAN;
                        if (r_i + 1'b1 == r_count) begin
                            r_i <= '0;
                            if (r_level == '0) begin
                                r_phase <= imf_pkg::PH_EMIT;
                            end else begin
                                r_level <= r_level - 1'b1;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                imf_pkg::PH_EMIT: begin
                    // sub 0: issue read of r_i; sub 1: load output; sub 2: wait for take.
                    if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else if (r_sub == 2'd1) begin
                        o_valid      <= 1'b1;
                        o_cand_index <= imf_pkg::IDX_W'(r_i);
                        o_ply        <= r_pc_q;
                        o_is_maximal <= r_keep_q;
                        o_run_last   <= (r_i + 1'b1 == r_count);
                        r_sub        <= 2'd2;
                    end else if (w_out_acc) begin
                        o_valid <= 1'b0;
                        r_sub   <= 2'd0;
                        if (r_i + 1'b1 == r_count) begin
                            r_phase <= imf_pkg::PH_LOAD;
                            r_count <= '0;
                            r_i     <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: begin
                    r_phase <= imf_pkg::PH_LOAD;
                end
            endcase
        end
    end

    `IMF_ASSERT_IMPL(a_no_load_while_out, i_clk, i_rst_n, o_valid, !o_ready)
    `IMF_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_CANDIDATES))
    `IMF_ASSERT_IMPL(a_surv_bound, i_clk, i_rst_n, 1'b1, r_surv_cnt <= CW'(MAX_CANDIDATES))
    `IMF_ASSERT_NEXT(a_last_returns, i_clk, i_rst_n, w_out_acc && o_run_last,
        r_phase == imf_pkg::PH_LOAD && r_count == '0)
endmodule

[hw/rtl/imf_popcount.sv]
// Registered popcount: counts of eight-bit slices are registered, then summed.
module imf_popcount #(
    parameter int MASK_BITS = 64
) (
    input  logic                      i_clk,
    input  logic [MASK_BITS-1:0]      i_value,
    output logic [imf_pkg::PLY_W-1:0] o_count
);
    logic [63:0] w_ext;
    logic [3:0]  r_part [8];

    assign w_ext = 64'(i_value);

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 8; g++) begin
            r_part[g] <= 4'(imf_pkg::popcount64({56'd0, w_ext[g*8 +: 8]}));
        end
    end

    always_comb begin
        o_count = '0;
        for (int g = 0; g < 8; g++) begin
            o_count = o_count + {3'd0, r_part[g]};
        end
    end
endmodule

[dv/inclusion_maximal_mask_filter_core_tb.sv]
module inclusion_maximal_mask_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CAND   = 64;
    // A wide margin over the worst-case filter pass for a full set, per idle stretch.
    localparam int IDLE_LIMIT = 100000;

    typedef struct packed {
        logic [imf_pkg::IDX_W-1:0] cand_index;
        logic [imf_pkg::PLY_W-1:0] ply;
        logic                      is_maximal;
        logic                      run_last;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_mask_inclusive = '0;
    logic [63:0] i_mask_conservative = '0;
    logic        i_set_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [imf_pkg::IDX_W-1:0] o_cand_index;
    logic [imf_pkg::PLY_W-1:0] o_ply;
    logic        o_is_maximal;
    logic        o_run_last;

    // Idle percentages for the sender and the receiver; changed per phase.
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;

    // Candidates of the open set, as the block will have stored them.
    logic [63:0] open_incl[$];
    logic [63:0] open_cons[$];
    t_verdict    pending_verdicts[$];

    always #4 i_clk = ~i_clk;

    inclusion_maximal_mask_filter_core i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mask_inclusive    (i_mask_inclusive),
        .i_mask_conservative (i_mask_conservative),
        .i_set_end           (i_set_end),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_cand_index        (o_cand_index),
        .o_ply               (o_ply),
        .o_is_maximal        (o_is_maximal),
        .o_run_last          (o_run_last)
    );

    function automatic int ones_in(logic [63:0] v);
        int n;
        n = 0;
        for (int k = 0; k < 64; k++) n += v[k];
        return n;
    endfunction

    // Run the dominance filter over the open set and queue one verdict per
    // candidate in arrival order; then start a new set.
    function automatic void close_set();
        int   count;
        int   n_surv;
        int   surv[MAX_CAND];
        int   pc[MAX_CAND];
        bit   keep[MAX_CAND];
        bit   covered;
        t_verdict v;
        count = open_incl.size();
        n_surv = 0;
        for (int i = 0; i < count; i++) begin
            pc[i] = ones_in(open_incl[i]);
            keep[i] = 1'b0;
        end
        // Visit by descending popcount, earlier arrival first on ties.
        for (int p = 64; p >= 0; p--) begin
            for (int i = 0; i < count; i++) begin
                if (pc[i] == p) begin
                    covered = 1'b0;
                    for (int s = 0; s < n_surv; s++) begin
                        if ((open_incl[i] & ~open_cons[surv[s]]) == '0) covered = 1'b1;
                    end
                    if (!covered) begin
                        keep[i] = 1'b1;
                        surv[n_surv] = i;
                        n_surv++;
                    end
                end
            end
        end
        for (int i = 0; i < count; i++) begin
            v.cand_index = i[imf_pkg::IDX_W-1:0];
            v.ply        = pc[i][imf_pkg::PLY_W-1:0];
            v.is_maximal = keep[i];
            v.run_last   = (i == count - 1);
            pending_verdicts = {pending_verdicts, v};
        end
        open_incl.delete();
        open_cons.delete();
    endfunction

    // Send one candidate transaction and update the prediction on acceptance.
    // Valid stays high after acceptance; a gap in the next send or a drain drops it.
    task automatic send_candidate(logic [63:0] incl, logic [63:0] cons, logic last);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_mask_inclusive    <= incl;
        i_mask_conservative <= cons;
        i_set_end           <= last;
        // Ready seen mid-cycle means the next rising edge takes the transaction.
        forever begin
            @(negedge i_clk);
            if (o_ready) break;
        end
        @(posedge i_clk);
        open_incl = {open_incl, incl};
        open_cons = {open_cons, cons};
        // A set that fills the last slot closes by itself.
        if (last || open_incl.size() == MAX_CAND) close_set();
    endtask

    // Random mask with a bias toward sparse, dense and edge patterns.
    function automatic logic [63:0] rand_mask();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(4))
            0: m = m & {$urandom, $urandom} & {$urandom, $urandom};
            1: m = m | {$urandom, $urandom};
            2: m = m & 64'h0000_0000_0000_00ff;
            default: ;
        endcase
        return m;
    endfunction

    // Send a set of nsize candidates; a chosen share is built to be dominated
    // by earlier members so that the filter drops some.
    task automatic send_random_set(int nsize);
        logic [63:0] incl;
        logic [63:0] cons;
        logic [63:0] seen_cons[$];
        for (int i = 0; i < nsize; i++) begin
            cons = rand_mask();
            if (seen_cons.size() != 0 && $urandom_range(2) == 0) begin
                incl = seen_cons[$urandom_range(seen_cons.size() - 1)] & rand_mask();
            end else begin
                incl = rand_mask();
            end
            cons = cons | incl;
            seen_cons = {seen_cons, cons};
            send_candidate(incl, cons, i == nsize - 1);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Receiver: stall at random, check each verdict against the oldest expected.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result cand_index=%0d", o_cand_index);
                    error_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_cand_index !== want.cand_index) begin
                        $error("cand_index: expected %0d got %0d", want.cand_index, o_cand_index);
                        error_count++;
                    end
                    if (o_ply !== want.ply) begin
                        $error("ply: expected %0d got %0d", want.ply, o_ply);
                        error_count++;
                    end
                    if (o_is_maximal !== want.is_maximal) begin
                        $error("is_maximal: expected %0d got %0d", want.is_maximal,
                               o_is_maximal);
                        error_count++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $error("run_last: expected %0d got %0d", want.run_last, o_run_last);
                        error_count++;
                    end
                end
            end
            i_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("inclusion_maximal_mask_filter_core_tb: errors");
                $finish;
            end
        end
    end

    // Extremes: all-zero and all-one masks, single-candidate set, duplicates.
    task automatic test_extremes();
        send_candidate('0, '0, 1'b1);
        send_candidate('1, '1, 1'b0);
        send_candidate('1, '0, 1'b0);
        send_candidate('0, '1, 1'b0);
        send_candidate(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b1);
    endtask

    // Ties on popcount: earlier arrival wins; subset drop and partial overlap.
    task automatic test_ties_and_subsets();
        send_candidate(64'h0f, 64'h0f, 1'b0);
        send_candidate(64'h0f, 64'h0f, 1'b0);
        send_candidate(64'h03, 64'h03, 1'b0);
        send_candidate(64'hf0, 64'hf0, 1'b0);
        send_candidate(64'h1e, 64'h1f, 1'b0);
        send_candidate(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    endtask

    // Overflow: 64 candidates with no set_end close the set on their own.
    task automatic test_overflow();
        for (int i = 0; i < MAX_CAND; i++) send_candidate(rand_mask(), rand_mask(), 1'b0);
    endtask

    task automatic test_random(int total);
        int sent;
        int nsize;
        sent = 0;
        while (sent < total) begin
            nsize = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            send_random_set(nsize);
            sent += nsize;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_ties_and_subsets();
        wait_drained();
        test_overflow();
        wait_drained();

        test_random(20);
        send_gap_pct = 68;
        test_random(20);
        send_gap_pct = 0;
        recv_stall_pct = 68;
        test_random(20);
        send_gap_pct = 16;
        recv_stall_pct = 16;
        test_random(20);
        wait_drained();

        if (error_count == 0) begin
            $display("inclusion_maximal_mask_filter_core_tb: clean");
        end else begin
            $display("inclusion_maximal_mask_filter_core_tb: errors");
        end
        $finish;
    end
endmodule
